### design/ill_pkg.sv
// ----------------------------------------------------------------------------
// INI line lexer package
// Character codes, lexeme modes, result kinds and the event struct that the
// tokenizer hands to the record walker.
// ----------------------------------------------------------------------------
package ill_pkg;

  localparam int BUF_CHARS_DEF = 16;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [1:0] MODE_SECTION = 2'd0;
  localparam logic [1:0] MODE_KEY     = 2'd1;
  localparam logic [1:0] MODE_VALUE   = 2'd2;
  localparam logic [1:0] MODE_COMMENT = 2'd3;

  localparam logic [2:0] KIND_SECTION = 3'd0;
  localparam logic [2:0] KIND_KEY     = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_REC_END = 3'd3;
  localparam logic [2:0] KIND_STREAM  = 3'd4;

  typedef struct packed {
    logic emit;
    logic eos;
    logic no_record;
  } tok_evt_t;

endpackage

### design/ill_buf_mem.sv
// ----------------------------------------------------------------------------
// INI line lexer buffer memory
// Holds the section, key and value buffers in one synchronous RAM with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module ill_buf_mem #(
  parameter int BUF_CHARS = 16,
  localparam int IDX_W    = (BUF_CHARS > 1) ? $clog2(BUF_CHARS) : 1,
  localparam int ADDR_W   = IDX_W + 2,
  localparam int DEPTH    = 3 * (1 << IDX_W)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/ill_tokenizer.sv
// ----------------------------------------------------------------------------
// INI line lexer tokenizer
// Tracks the lexeme mode, the buffer fill counts and the trim bounds of each
// buffer, and writes accepted characters into the buffer memory.
// ----------------------------------------------------------------------------
module ill_tokenizer import ill_pkg::*; #(
  parameter int BUF_CHARS = 16,
  localparam int IDX_W    = (BUF_CHARS > 1) ? $clog2(BUF_CHARS) : 1,
  localparam int CNT_W    = $clog2(BUF_CHARS + 1),
  localparam int ADDR_W   = IDX_W + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        ch,
  input  logic              eos,
  output tok_evt_t          evt,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              sec_has,
  output logic [CNT_W-1:0]  sec_lo,
  output logic [CNT_W-1:0]  sec_hi,
  output logic              key_has,
  output logic [CNT_W-1:0]  key_lo,
  output logic [CNT_W-1:0]  key_hi,
  output logic              val_has,
  output logic [CNT_W-1:0]  val_lo,
  output logic [CNT_W-1:0]  val_hi
);

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic             has;
  } trk_t;

  typedef struct packed {
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic             has;
  } bnd_t;

  localparam trk_t TRK_CLR = '0;
  localparam bnd_t BND_CLR = '0;

  logic [1:0] mode_r, mode_nxt;
  logic [1:0] prev_r, prev_nxt;
  logic       seen_r, seen_nxt;
  trk_t       sec_r, sec_nxt;
  trk_t       key_r, key_nxt;
  trk_t       val_r, val_nxt;
  bnd_t       secb_r, secb_nxt;
  bnd_t       keyb_r, keyb_nxt;
  logic       emit;

  function automatic trk_t trk_add(input trk_t t, input logic [7:0] c);
    trk_t r;
    r = t;
    if (c != CH_SPACE) begin
      if (!t.has) begin
        r.lo = t.fill;
      end
      r.has = 1'b1;
      r.hi  = t.fill + CNT_W'(1);
    end
    r.fill = t.fill + CNT_W'(1);
    return r;
  endfunction

  assign emit = (ch == CH_NEWLINE) &&
                ((mode_r == MODE_VALUE) ||
                 ((mode_r == MODE_COMMENT) && (prev_r == MODE_VALUE)));

  assign evt.emit      = !eos && emit;
  assign evt.eos       = eos;
  assign evt.no_record = !seen_r;

  always_comb begin
    mode_nxt = mode_r;
    prev_nxt = prev_r;
    seen_nxt = seen_r;
    sec_nxt  = sec_r;
    key_nxt  = key_r;
    val_nxt  = val_r;
    secb_nxt = secb_r;
    keyb_nxt = keyb_r;
    wr_en    = 1'b0;
    wr_addr  = {mode_r, sec_r.fill[IDX_W-1:0]};
    wr_data  = ch;
    if (acc && !eos) begin
      if ((ch == CH_HASH) || (ch == CH_SEMI)) begin
        prev_nxt = mode_r;
        mode_nxt = MODE_COMMENT;
      end else if (ch == CH_LBRACK) begin
        mode_nxt = MODE_SECTION;
        sec_nxt  = TRK_CLR;
        secb_nxt = BND_CLR;
      end else if (ch == CH_RBRACK) begin
        mode_nxt = MODE_KEY;
        secb_nxt = '{lo: sec_r.lo, hi: sec_r.hi, has: sec_r.has};
      end else if ((ch == CH_EQUAL) && (mode_r != MODE_VALUE)) begin
        mode_nxt = MODE_VALUE;
        keyb_nxt = '{lo: key_r.lo, hi: key_r.hi, has: key_r.has};
        key_nxt  = TRK_CLR;
      end else if (ch == CH_NEWLINE) begin
        if (emit) begin
          seen_nxt = 1'b1;
        end
        mode_nxt = MODE_KEY;
        key_nxt  = TRK_CLR;
        val_nxt  = TRK_CLR;
      end else begin
        case (mode_r)
          MODE_SECTION: begin
            wr_addr = {mode_r, sec_r.fill[IDX_W-1:0]};
            if (sec_r.fill < CNT_W'(BUF_CHARS)) begin
              wr_en   = 1'b1;
              sec_nxt = trk_add(sec_r, ch);
            end
          end
          MODE_KEY: begin
            wr_addr = {mode_r, key_r.fill[IDX_W-1:0]};
            if (key_r.fill < CNT_W'(BUF_CHARS)) begin
              wr_en   = 1'b1;
              key_nxt = trk_add(key_r, ch);
            end
          end
          MODE_VALUE: begin
            wr_addr = {mode_r, val_r.fill[IDX_W-1:0]};
            if (val_r.fill < CNT_W'(BUF_CHARS)) begin
              wr_en   = 1'b1;
              val_nxt = trk_add(val_r, ch);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_KEY;
      prev_r <= MODE_KEY;
      seen_r <= 1'b0;
      sec_r  <= TRK_CLR;
      key_r  <= TRK_CLR;
      val_r  <= TRK_CLR;
      secb_r <= BND_CLR;
      keyb_r <= BND_CLR;
    end else begin
      mode_r <= mode_nxt;
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
      sec_r  <= sec_nxt;
      key_r  <= key_nxt;
      val_r  <= val_nxt;
      secb_r <= secb_nxt;
      keyb_r <= keyb_nxt;
    end
  end

  assign sec_has = secb_r.has;
  assign sec_lo  = secb_r.lo;
  assign sec_hi  = secb_r.hi;
  assign key_has = keyb_r.has;
  assign key_lo  = keyb_r.lo;
  assign key_hi  = keyb_r.hi;
  assign val_has = val_r.has;
  assign val_lo  = val_r.lo;
  assign val_hi  = val_r.hi;

endmodule

### design/ini_line_lexer.sv
// ----------------------------------------------------------------------------
// INI line lexer
// Byte-serial INI lexer that emits trimmed section, key and value records.
// ----------------------------------------------------------------------------
// Ordinary bytes, and newlines that end no record, are taken one per cycle.
// A newline that ends a record stalls the input while the record is walked
// out of the buffer memory: each emitted character is a read of the single
// read port followed by a load of the output register, and the walk steps
// over the three fields in turn and ends with the record-end transaction.
// An end-of-stream byte stalls the input until its transaction is issued.
// Output back-pressure can hold the walk and both end transactions.
module ini_line_lexer import ill_pkg::*; #(
  parameter int BUF_CHARS = BUF_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_char,
  output logic       out_status,
  output logic       out_last
);

  localparam int IDX_W  = (BUF_CHARS > 1) ? $clog2(BUF_CHARS) : 1;
  localparam int CNT_W  = $clog2(BUF_CHARS + 1);
  localparam int ADDR_W = IDX_W + 2;
  localparam logic [1:0] PH_END = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_REND,
    ST_EOS
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              vsn_has_r, vsn_has_nxt;
  logic [CNT_W-1:0]  vsn_lo_r, vsn_lo_nxt;
  logic [CNT_W-1:0]  vsn_hi_r, vsn_hi_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_kind_r, out_kind_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  tok_evt_t          evt;
  logic              acc;
  logic              out_free;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              sec_has, key_has, val_has;
  logic [CNT_W-1:0]  sec_lo, sec_hi, key_lo, key_hi, val_lo, val_hi;
  logic              w_has [4];
  logic [CNT_W-1:0]  w_lo  [4];
  logic [CNT_W-1:0]  w_hi  [4];
  logic [1:0]        phase_inc;

  ill_tokenizer #(.BUF_CHARS(BUF_CHARS)) u_tok (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .ch      (in_ch),
    .eos     (in_end_of_stream),
    .evt     (evt),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .sec_has (sec_has),
    .sec_lo  (sec_lo),
    .sec_hi  (sec_hi),
    .key_has (key_has),
    .key_lo  (key_lo),
    .key_hi  (key_hi),
    .val_has (val_has),
    .val_lo  (val_lo),
    .val_hi  (val_hi)
  );

  ill_buf_mem #(.BUF_CHARS(BUF_CHARS)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign phase_inc = phase_r + 2'd1;
  assign rd_addr   = {phase_r, ptr_r[IDX_W-1:0]};

  assign w_has[0] = sec_has;
  assign w_has[1] = key_has;
  assign w_has[2] = vsn_has_r;
  assign w_has[3] = 1'b0;
  assign w_lo[0]  = sec_lo;
  assign w_lo[1]  = key_lo;
  assign w_lo[2]  = vsn_lo_r;
  assign w_lo[3]  = '0;
  assign w_hi[0]  = sec_hi;
  assign w_hi[1]  = key_hi;
  assign w_hi[2]  = vsn_hi_r;
  assign w_hi[3]  = '0;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    ptr_nxt        = ptr_r;
    vsn_has_nxt    = vsn_has_r;
    vsn_lo_nxt     = vsn_lo_r;
    vsn_hi_nxt     = vsn_hi_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_char_nxt   = out_char_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (evt.eos) begin
            state_nxt = ST_EOS;
          end else if (evt.emit) begin
            state_nxt   = ST_SCAN;
            phase_nxt   = MODE_SECTION;
            ptr_nxt     = sec_lo;
            vsn_has_nxt = val_has;
            vsn_lo_nxt  = val_lo;
            vsn_hi_nxt  = val_hi;
          end
        end
      end
      ST_SCAN: begin
        if (phase_r == PH_END) begin
          state_nxt = ST_REND;
        end else if (w_has[phase_r] && (ptr_r < w_hi[phase_r])) begin
          if (out_free) begin
            rd_en     = 1'b1;
            ptr_nxt   = ptr_r + CNT_W'(1);
            state_nxt = ST_LOAD;
          end
        end else begin
          phase_nxt = phase_inc;
          ptr_nxt   = w_lo[phase_inc];
        end
      end
      ST_LOAD: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = {1'b0, phase_r};
        out_char_nxt   = rd_data;
        out_status_nxt = 1'b0;
        out_last_nxt   = 1'b0;
        state_nxt      = ST_SCAN;
      end
      ST_REND: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_REC_END;
          out_char_nxt   = '0;
          out_status_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_EOS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STREAM;
          out_char_nxt   = '0;
          out_status_nxt = evt.no_record;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    phase_r      <= phase_nxt;
    ptr_r        <= ptr_nxt;
    vsn_has_r    <= vsn_has_nxt;
    vsn_lo_r     <= vsn_lo_nxt;
    vsn_hi_r     <= vsn_hi_nxt;
    out_kind_r   <= out_kind_nxt;
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_char   = out_char_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

### tb/ini_line_lexer_tb.sv
// ----------------------------------------------------------------------------
// INI line lexer testbench
// Drives byte streams of INI text through the lexer under random sender
// idling and receiver stalls, predicts every section, key and value character
// as well as the record and stream end markers, and compares each result
// transaction with the oldest predicted token.
// ----------------------------------------------------------------------------
module ini_line_lexer_tb import ill_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_CHARS = BUF_CHARS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 120;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       status;
    logic       last;
  } token_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_ch;
  logic       in_end_of_stream;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_kind;
  logic [7:0] out_char;
  logic       out_status;
  logic       out_last;

  token_t     pending_tokens[$];
  int         errors;
  int         items_sent;
  int         idle_pct;
  int         stall_pct;
  int         quiet_cycles;

  logic [7:0] sec_chars[BUF_CHARS];
  logic [7:0] key_chars[BUF_CHARS];
  logic [7:0] val_chars[BUF_CHARS];
  int         sec_fill;
  int         sec_len;
  int         key_fill;
  int         key_len;
  int         val_fill;
  logic [1:0] lex_mode;
  logic [1:0] saved_mode;
  logic       any_record;

  ini_line_lexer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_char         (out_char),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_trimmed(input logic [7:0] chars[BUF_CHARS], input int len,
                                       input logic [2:0] kind);
    int lo;
    int hi;
    lo = 0;
    while (lo < len && chars[lo] == CH_SPACE) lo++;
    hi = len;
    while (hi > lo && chars[hi - 1] == CH_SPACE) hi--;
    for (int i = lo; i < hi; i++) begin
      pending_tokens.push_back(token_t'{kind, chars[i], 1'b0, 1'b0});
    end
  endfunction

  function automatic void lex_byte(input logic [7:0] ch, input logic eos);
    if (eos) begin
      pending_tokens.push_back(token_t'{KIND_STREAM, 8'h00, !any_record, 1'b1});
    end else if (ch == CH_HASH || ch == CH_SEMI) begin
      saved_mode = lex_mode;
      lex_mode = MODE_COMMENT;
    end else if (ch == CH_LBRACK) begin
      lex_mode = MODE_SECTION;
      sec_fill = 0;
      sec_len = 0;
    end else if (ch == CH_RBRACK) begin
      lex_mode = MODE_KEY;
      sec_len = sec_fill;
    end else if (ch == CH_EQUAL && lex_mode != MODE_VALUE) begin
      lex_mode = MODE_VALUE;
      key_len = key_fill;
      key_fill = 0;
    end else if (ch == CH_NEWLINE) begin
      if (lex_mode == MODE_VALUE || (lex_mode == MODE_COMMENT && saved_mode == MODE_VALUE)) begin
        push_trimmed(sec_chars, sec_len, KIND_SECTION);
        push_trimmed(key_chars, key_len, KIND_KEY);
        push_trimmed(val_chars, val_fill, KIND_VALUE);
        pending_tokens.push_back(token_t'{KIND_REC_END, 8'h00, 1'b0, 1'b1});
        any_record = 1'b1;
      end
      lex_mode = MODE_KEY;
      key_fill = 0;
      val_fill = 0;
    end else begin
      case (lex_mode)
        MODE_SECTION: if (sec_fill < BUF_CHARS) begin
          sec_chars[sec_fill] = ch;
          sec_fill++;
        end
        MODE_KEY: if (key_fill < BUF_CHARS) begin
          key_chars[key_fill] = ch;
          key_fill++;
        end
        MODE_VALUE: if (val_fill < BUF_CHARS) begin
          val_chars[val_fill] = ch;
          val_fill++;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void note_error(input string what);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endfunction

  function automatic logic is_marker(input logic [7:0] ch);
    return ch == CH_HASH || ch == CH_SEMI || ch == CH_LBRACK || ch == CH_RBRACK ||
           ch == CH_EQUAL || ch == CH_NEWLINE;
  endfunction

  function automatic logic [7:0] any_marker();
    case ($urandom_range(5))
      0: return CH_HASH;
      1: return CH_SEMI;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return CH_EQUAL;
      default: return CH_NEWLINE;
    endcase
  endfunction

  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        note_error($sformatf("unexpected transaction kind %0d char %02h status %0b last %0b",
                             out_kind, out_char, out_status, out_last));
      end else begin
        want = pending_tokens.pop_front();
        if (out_kind !== want.kind || out_char !== want.ch || out_status !== want.status ||
            out_last !== want.last) begin
          note_error($sformatf({"mismatch: expected kind %0d char %02h status %0b last %0b,",
                                " got kind %0d char %02h status %0b last %0b"},
                               want.kind, want.ch, want.status, want.last,
                               out_kind, out_char, out_status, out_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eos);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_ch <= ch;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lex_byte(ch, eos);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic drain_tokens();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  task automatic send_field(input logic allow_equal);
    int len;
    logic [7:0] ch;
    len = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) < 3) begin
        ch = CH_SPACE;
      end else begin
        do ch = 8'($urandom_range(255));
        while (is_marker(ch) && !(allow_equal && ch == CH_EQUAL));
      end
      send_item(ch, 1'b0);
    end
  endtask

  task automatic test_stream_end_status();
    send_item(8'hFF, 1'b1);
    send_text("#a=b\nkey\n");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_trimmed_record();
    send_text("[ ab ]\n k = v");
    send_item(8'h00, 1'b0);
    send_text(" ;c\n");
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_special_lines();
    send_text("[q\n=");
    send_item(8'hFF, 1'b0);
    send_text(" \na=  \na=b=c\nk=v#c;d\nx=1]\n");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_full_buffers();
    send_item(CH_LBRACK, 1'b0);
    for (int i = 0; i < BUF_CHARS + 2; i++) send_item(8'(8'h61 + i), 1'b0);
    send_text("]\n");
    for (int i = 0; i < BUF_CHARS + 2; i++) send_item(8'(8'h41 + i), 1'b0);
    send_item(CH_EQUAL, 1'b0);
    for (int i = 0; i < BUF_CHARS + 2; i++) send_item(8'(8'h30 + i), 1'b0);
    send_item(CH_NEWLINE, 1'b0);
  endtask

  task automatic test_random_stream(input int idle, input int stall, input int n_items);
    int target;
    int pick;
    target = items_sent + n_items;
    idle_pct = idle;
    stall_pct = stall;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_item(CH_LBRACK, 1'b0);
        send_field(1'b0);
        if ($urandom_range(4) != 0) send_item(CH_RBRACK, 1'b0);
        send_item(CH_NEWLINE, 1'b0);
      end else if (pick < 75) begin
        send_field(1'b0);
        send_item(CH_EQUAL, 1'b0);
        send_field(1'b1);
        if ($urandom_range(3) == 0) begin
          send_item($urandom_range(1) ? CH_HASH : CH_SEMI, 1'b0);
          send_field(1'b1);
        end
        send_item(CH_NEWLINE, 1'b0);
      end else if (pick < 85) begin
        send_item($urandom_range(1) ? CH_HASH : CH_SEMI, 1'b0);
        send_field(1'b1);
        send_item(CH_NEWLINE, 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(7) == 0) begin
            send_item(8'($urandom_range(255)), 1'b1);
          end else if ($urandom_range(2) == 0) begin
            send_item(any_marker(), 1'b0);
          end else begin
            send_item(8'($urandom_range(255)), 1'b0);
          end
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_ch <= 8'h00;
    in_end_of_stream <= 1'b0;
    out_ready <= 1'b0;
    errors = 0;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles <= 0;
    for (int i = 0; i < BUF_CHARS; i++) begin
      sec_chars[i] = 8'h00;
      key_chars[i] = 8'h00;
      val_chars[i] = 8'h00;
    end
    sec_fill = 0;
    sec_len = 0;
    key_fill = 0;
    key_len = 0;
    val_fill = 0;
    lex_mode = MODE_KEY;
    saved_mode = MODE_KEY;
    any_record = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_stream_end_status();
    test_trimmed_record();
    test_special_lines();
    test_full_buffers();
    test_random_stream(0, 0, 25);
    drain_tokens();
    test_random_stream(81, 0, 25);
    test_random_stream(0, 81, 25);
    test_random_stream(31, 31, 25);
    test_random_stream(0, 0, 10);

    stall_pct = 0;
    drain_tokens();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      note_error($sformatf("%0d predicted tokens never arrived", pending_tokens.size()));
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
